FILE: sv/b2d_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds the digit constants, the BCD digit vector type and the add-3 helper.
// No dependencies; used by every other file of the block.
package b2d_pkg;

	localparam int DIGITS      = 20;
	localparam int DIGIT_W     = 4;
	localparam int VALUE_W     = 64;
	localparam int CNT_W       = 5;
	localparam int BIT_CNT_W   = 6;
	localparam int CHAR_W      = 6;
	localparam int TOTAL_W     = 32;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef logic [DIGITS-1:0][DIGIT_W-1:0] digits_t;

	// Finished conversion handed from the converter to the emitter.
	typedef struct packed {
		logic              valid;
		digits_t           digits;
		logic [CNT_W-1:0]  count;
	} conv_res_t;

	// Double-dabble correction: every digit of five or more gets three added.
	function automatic digits_t add3(input digits_t d);
		digits_t r;
		for (int i = 0; i < DIGITS; i++) begin
			if (d[i] >= 4'd5) begin
				r[i] = d[i] + 4'd3;
			end else begin
				r[i] = d[i];
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/b2d_in_if.sv
// Input channel of the converter: valid/ready handshake with the operand.
// Depends on b2d_pkg for the operand width.
interface b2d_in_if;
	logic                       valid;
	logic                       ready;
	logic [b2d_pkg::VALUE_W-1:0] value_bits;
	logic                       is_signed;

	modport source (output valid, output value_bits, output is_signed, input ready);
	modport sink (input valid, input value_bits, input is_signed, output ready);
endinterface

FILE: sv/b2d_out_if.sv
// Output channel of the converter: one transfer per emitted decimal digit.
// Depends on b2d_pkg for the field widths.
interface b2d_out_if;
	logic                        valid;
	logic                        ready;
	logic [b2d_pkg::CHAR_W-1:0]  digit_char;
	logic [b2d_pkg::CNT_W-1:0]   digit_position;
	logic [b2d_pkg::CNT_W-1:0]   digit_count;
	logic                        last_digit;
	logic [b2d_pkg::TOTAL_W-1:0] chars_emitted;

	modport source (output valid, output digit_char, output digit_position,
		output digit_count, output last_digit, output chars_emitted, input ready);
	modport sink (input valid, input digit_char, input digit_position,
		input digit_count, input last_digit, input chars_emitted, output ready);
endinterface

FILE: sv/b2d_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one operand bit per cycle.
// Tracks the decimal digit count as the BCD value grows.
// Depends on b2d_pkg and b2d_in_if.
module b2d_dabble (
	input  logic                clk,
	input  logic                arst_n,
	b2d_in_if.sink              din,
	output b2d_pkg::conv_res_t  res,
	input  logic                take
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                      state_q;
	logic [b2d_pkg::VALUE_W-1:0]     mag_q;
	b2d_pkg::digits_t                bcd_q;
	logic [b2d_pkg::CNT_W-1:0]       ndig_q;
	logic [b2d_pkg::BIT_CNT_W-1:0]   bit_q;
	b2d_pkg::digits_t                bcd_adj;
	b2d_pkg::digits_t                bcd_next;
	logic [b2d_pkg::VALUE_W-1:0]     mag_in;
	logic                            grow;

	assign din.ready = (state_q == ST_IDLE);

	// Magnitude of the operand: negate when it is read as a negative signed value.
	always_comb begin
		if (din.is_signed && din.value_bits[b2d_pkg::VALUE_W-1]) begin
			mag_in = ~din.value_bits + 64'd1;
		end else begin
			mag_in = din.value_bits;
		end
	end

	// One double-dabble step, and whether the next digit up became nonzero.
	// The whole BCD vector shifts left by one bit; the top bit of the highest
	// digit drops out, which never holds a one for a 64-bit operand.
	always_comb begin
		bcd_adj  = b2d_pkg::add3(bcd_q);
		bcd_next = {bcd_adj[b2d_pkg::DIGITS-1][b2d_pkg::DIGIT_W-2:0],
			bcd_adj[b2d_pkg::DIGITS-2:0], mag_q[b2d_pkg::VALUE_W-1]};
		grow = 1'b0;
		if (ndig_q < 5'(b2d_pkg::DIGITS)) begin
			grow = (bcd_next[ndig_q] != 4'd0);
		end
	end

	// Sequencer: load, shift one bit per cycle, then hold until handed off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			ndig_q  <= 5'd1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						state_q <= ST_BUSY;
						bit_q   <= '0;
						ndig_q  <= 5'd1;
					end
				end
				ST_BUSY: begin
					bit_q <= bit_q + 6'd1;
					if (grow) begin
						ndig_q <= ndig_q + 5'd1;
					end
					if (bit_q == 6'(b2d_pkg::VALUE_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && din.valid) begin
			mag_q <= mag_in;
			bcd_q <= '0;
		end else if (state_q == ST_BUSY) begin
			mag_q <= {mag_q[b2d_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign res.valid  = (state_q == ST_DONE);
	assign res.digits = bcd_q;
	assign res.count  = ndig_q;

	// A transfer always starts a conversion.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> state_q == ST_BUSY)
		else $error("conversion did not start after input transfer");

	// The digit count stays within one to twenty.
	a_ndig: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q >= 5'd1 && ndig_q <= 5'(b2d_pkg::DIGITS))
		else $error("digit count out of range");

	// A finished result holds until the emitter takes it.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !take |=> res.valid && $stable(res.count))
		else $error("finished result lost before hand-off");

endmodule

FILE: sv/b2d_emit.sv
// Digit emitter: walks the BCD digits from the most significant one down,
// one digit per transfer, through an output register; keeps the character count.
// Depends on b2d_pkg and b2d_out_if.
module b2d_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  b2d_pkg::conv_res_t  res,
	output logic                take,
	b2d_out_if.source           dout
);

	logic                          busy_q;
	b2d_pkg::digits_t              dig_q;
	logic [b2d_pkg::CNT_W-1:0]     count_q;
	logic [b2d_pkg::CNT_W-1:0]     pos_q;
	logic [b2d_pkg::CNT_W-1:0]     ptr_q;
	logic [b2d_pkg::TOTAL_W-1:0]   total_q;
	logic                          ovalid_q;
	logic [b2d_pkg::CHAR_W-1:0]    char_q;
	logic [b2d_pkg::CNT_W-1:0]     opos_q;
	logic [b2d_pkg::CNT_W-1:0]     ocount_q;
	logic                          olast_q;
	logic [b2d_pkg::TOTAL_W-1:0]   ochars_q;
	logic                          advance;
	logic                          is_last;

	assign take    = res.valid && !busy_q;
	assign advance = busy_q && (!ovalid_q || dout.ready);
	assign is_last = (ptr_q == 5'd0);

	// Control: run state, digit pointer, output valid and running count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			total_q  <= '0;
			ptr_q    <= '0;
			pos_q    <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				ptr_q  <= res.count - 5'd1;
				pos_q  <= '0;
			end else if (advance) begin
				total_q <= total_q + 32'd1;
				ptr_q   <= ptr_q - 5'd1;
				pos_q   <= pos_q + 5'd1;
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (dout.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Payload: digits of the current run and the output register.
	always_ff @(posedge clk) begin
		if (take) begin
			dig_q   <= res.digits;
			count_q <= res.count;
		end
		if (advance) begin
			char_q   <= b2d_pkg::ASCII_ZERO + {2'b00, dig_q[ptr_q]};
			opos_q   <= pos_q;
			ocount_q <= count_q;
			olast_q  <= is_last;
			ochars_q <= total_q + 32'd1;
		end
	end

	assign dout.valid          = ovalid_q;
	assign dout.digit_char     = char_q;
	assign dout.digit_position = opos_q;
	assign dout.digit_count    = ocount_q;
	assign dout.last_digit     = olast_q;
	assign dout.chars_emitted  = ochars_q;

	// The last mark falls exactly on the final position of the run.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.last_digit == (dout.digit_position == dout.digit_count - 5'd1)))
		else $error("last digit mark misplaced");

	// Only decimal digit characters are shown.
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> dout.digit_char >= 6'd48 && dout.digit_char <= 6'd57)
		else $error("digit character out of range");

	// The running count moves by exactly one per loaded digit.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> total_q == $past(total_q) + 32'd1)
		else $error("character count skipped");

endmodule

FILE: sv/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: 64-bit operand in, one ASCII digit per transfer out.
// The first digit follows the bit-serial shift-and-add-3 loop (64 steps), the hand-off
// and the output register; then one digit per cycle of an item while the sink is ready.
// The 1 to 20 digits of an item are emitted while the next one converts.
// Reset: asynchronous, active low; clears the control state and the character count.
module binary_to_decimal_ascii (
	input  logic clk,
	input  logic arst_n,
	b2d_in_if.sink    din,
	b2d_out_if.source dout
);

	b2d_pkg::conv_res_t res;
	logic               take;

	// Bit-serial BCD conversion.
	b2d_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.res    (res),
		.take   (take)
	);

	// Digit emission and output register.
	b2d_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.take   (take),
		.dout   (dout)
	);

endmodule
